// File: hdl/wpm_pkg.sv
// Shared types, sizes and symbol codes for the wildcard pattern matcher.
package wpm_pkg;

  localparam int MaxPattern = 128;
  localparam int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int ReachW     = MaxPattern + 1;

  localparam int QueueDepth = 2;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam logic [7:0] SymAnyOne = 8'h3F;
  localparam logic [7:0] SymAnyRun = 8'h2A;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       is_star;
    logic       is_any;
  } cmd_t;

endpackage

// File: hdl/wpm_ifs.sv
// Request and result channel interfaces of the wildcard pattern matcher.
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] ch;

  modport source (output valid, output mode, output ch, input ready);
  modport sink (input valid, input mode, input ch, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflowed;

  modport source (output valid, output matched, output pattern_overflowed, input ready);
  modport sink (input valid, input matched, input pattern_overflowed, output ready);
endinterface

// File: hdl/wpm_front.sv
// Front end: accepts requests and decodes mode and symbol class.
module wpm_front (
  wpm_in_if.sink        item,
  input  logic          full,
  output logic          push,
  output wpm_pkg::cmd_t cmd
);
  import wpm_pkg::*;

  assign item.ready  = ~full;
  assign push        = item.valid & ~full;
  assign cmd.op      = op_t'(item.mode);
  assign cmd.ch      = item.ch;
  assign cmd.is_star = (item.ch == SymAnyRun);
  assign cmd.is_any  = (item.ch == SymAnyOne);

endmodule

// File: hdl/wpm_queue.sv
// Short command queue between the front end and the back end.
module wpm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wpm_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output wpm_pkg::cmd_t pop_cmd
);
  import wpm_pkg::*;

  cmd_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CntW'(QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// File: hdl/wpm_back.sv
// Back end: pattern store, reach-set update with star closure, result register.
module wpm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  wpm_pkg::cmd_t cmd,
  output logic          pop,
  wpm_out_if.source     result
);
  import wpm_pkg::*;

  logic [7:0]            pat_chars [MaxPattern];
  logic [MaxPattern-1:0] live;
  logic [MaxPattern-1:0] star;
  logic [MaxPattern-1:0] anyc;
  logic [LenW-1:0]       len;
  logic                  ovf;
  logic [ReachW-1:0]     start_set;
  logic [ReachW-1:0]     start_set_next;
  logic [ReachW-1:0]     reach;
  logic [ReachW-1:0]     reach_next;
  logic                  out_valid;
  logic                  out_matched;
  logic                  out_ovf;

  logic [MaxPattern-1:0] hit;
  logic [MaxPattern-1:0] stay;
  logic [ReachW-1:0]     step_set;
  logic [ReachW-1:0]     prop;
  logic [ReachW-1:0]     gen;
  logic [ReachW:0]       csum;
  logic [ReachW-1:0]     carry;
  logic [ReachW-1:0]     advanced;
  logic                  room;
  logic                  is_finish;

  assign is_finish = (cmd.op == OP_FINISH);
  assign pop       = cmd_valid & (~is_finish | ~out_valid | result.ready);
  assign room      = (len < LenW'(MaxPattern));

  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      hit[i] = reach[i] & live[i] & ~star[i] & (anyc[i] | (pat_chars[i] == cmd.ch));
    end
  end

  // Star closure as a carry chain: runs of stars propagate, reached stars generate.
  assign stay     = reach[MaxPattern-1:0] & live & star;
  assign step_set = {1'b0, stay} | {hit, 1'b0};
  assign prop     = {1'b0, star & live};
  assign gen      = step_set & prop;
  assign csum     = {1'b0, prop} + {1'b0, gen};
  assign carry    = csum[ReachW-1:0] ^ prop ^ gen;
  assign advanced = step_set | carry;

  always_comb begin
    start_set_next = start_set;
    if (cmd.op == OP_CLEAR) begin
      start_set_next = ReachW'(1);
    end else if (cmd.op == OP_APPEND && room) begin
      start_set_next[len + LenW'(1)] = start_set[len] & cmd.is_star;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_NAME: reach_next = advanced;
      default: reach_next = start_set_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.op == OP_APPEND && room) begin
      pat_chars[len[IdxW-1:0]] <= cmd.ch;
      star[len[IdxW-1:0]]      <= cmd.is_star;
      anyc[len[IdxW-1:0]]      <= cmd.is_any;
    end
    if (pop && is_finish) begin
      out_matched <= reach[len];
      out_ovf     <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      len       <= '0;
      ovf       <= 1'b0;
      start_set <= ReachW'(1);
      reach     <= ReachW'(1);
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        start_set <= start_set_next;
        reach     <= reach_next;
        unique case (cmd.op) inside
          OP_CLEAR: begin
            live <= '0;
            len  <= '0;
            ovf  <= 1'b0;
          end
          OP_APPEND: begin
            if (room) begin
              live[len[IdxW-1:0]] <= 1'b1;
              len                 <= len + LenW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          OP_NAME, OP_FINISH: begin
          end
          default: begin
          end
        endcase
      end
      if (pop && is_finish) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid              = out_valid;
  assign result.matched            = out_matched;
  assign result.pattern_overflowed = out_ovf;

endmodule

// File: hdl/wildcard_pattern_matcher_unit.sv
// Top level of the wildcard pattern matcher.
// Every request (clear, append pattern byte, name byte, finish) is handled by the back end
// as it leaves the queue, so the block sustains one request per cycle, including a continuous
// stream of name bytes, as long as no finish is held back by an earlier result not yet taken.
// That rate rests on the combinational reach-set update: one compare per pattern position
// and one carry-chain add across the pattern for star closure. A request passes a two-entry
// queue before it executes; a finish gives its result from a register in the cycle after it
// executes, and other requests keep flowing while that result waits. The pattern holds up to
// 128 bytes; further appends are dropped and flagged on each result until the next clear.
module wildcard_pattern_matcher_unit (
  input  logic      clk,
  input  logic      rst,
  wpm_in_if.sink    item,
  wpm_out_if.source result
);
  import wpm_pkg::*;

  logic full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic pop_valid;
  cmd_t pop_cmd;

  wpm_front u_front (
    .item (item),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  wpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  wpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .pop       (pop),
    .result    (result)
  );

endmodule

// File: dv/wildcard_pattern_matcher_unit_tb.sv
// Testbench for the wildcard pattern matcher: a directed table, then random patterns and names
// checked against a behavioral reach-set predictor.
module wildcard_pattern_matcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpm_pkg::*;

  localparam int NumItems   = 1000;
  localparam int StallLimit = 2000;
  localparam int DirRows    = 24;

  typedef struct packed {
    logic matched;
    logic ovf;
  } match_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       typed;
    match_t     want;
  } req_t;

  logic clk = 1'b0;
  logic rst;

  wpm_in_if  item ();
  wpm_out_if result ();

  wildcard_pattern_matcher_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  always #5 clk = ~clk;

  req_t dir_tab [0:DirRows-1] = '{
    '{OP_FINISH, 8'h00, 1'b1, '{1'b1, 1'b0}},
    '{OP_NAME,   "a",   1'b0, '{1'b0, 1'b0}},
    '{OP_FINISH, 8'h00, 1'b1, '{1'b0, 1'b0}},
    '{OP_APPEND, SymAnyRun, 1'b0, '{1'b0, 1'b0}},
    '{OP_FINISH, 8'h00, 1'b1, '{1'b1, 1'b0}},
    '{OP_NAME,   8'h00, 1'b0, '{1'b0, 1'b0}},
    '{OP_NAME,   8'hFF, 1'b0, '{1'b0, 1'b0}},
    '{OP_FINISH, 8'h00, 1'b1, '{1'b1, 1'b0}},
    '{OP_APPEND, SymAnyOne, 1'b0, '{1'b0, 1'b0}},
    '{OP_NAME,   "x",   1'b0, '{1'b0, 1'b0}},
    '{OP_FINISH, 8'h00, 1'b0, '{1'b0, 1'b0}},
    '{OP_NAME,   "q",   1'b0, '{1'b0, 1'b0}},
    '{OP_APPEND, 8'hFF, 1'b0, '{1'b0, 1'b0}},
    '{OP_NAME,   "z",   1'b0, '{1'b0, 1'b0}},
    '{OP_NAME,   8'hFF, 1'b0, '{1'b0, 1'b0}},
    '{OP_FINISH, 8'h00, 1'b0, '{1'b0, 1'b0}},
    '{OP_CLEAR,  8'hFF, 1'b0, '{1'b0, 1'b0}},
    '{OP_FINISH, 8'h00, 1'b1, '{1'b1, 1'b0}},
    '{OP_APPEND, 8'h00, 1'b0, '{1'b0, 1'b0}},
    '{OP_NAME,   8'h01, 1'b0, '{1'b0, 1'b0}},
    '{OP_NAME,   8'h00, 1'b0, '{1'b0, 1'b0}},
    '{OP_FINISH, 8'h00, 1'b0, '{1'b0, 1'b0}},
    '{OP_FINISH, 8'hA5, 1'b1, '{1'b0, 1'b0}},
    '{OP_CLEAR,  8'h00, 1'b0, '{1'b0, 1'b0}}
  };

  // predictor state
  logic [7:0]        pat_mem [MaxPattern];
  int unsigned       pat_len;
  logic              pat_ovf;
  logic [ReachW-1:0] reach;

  req_t       req_q [$];
  match_t     match_q [$];
  logic [7:0] gen_pat [$];
  req_t       cur_req;
  match_t     got;
  match_t     want_r;
  int         n_gen;
  int         n_acc;
  int         n_errors;
  int         idle_cycles;
  int         gap_left;
  int         burst_left;
  logic [15:0] stall_pat;
  int         stall_ph;

  function automatic void close_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (reach[i] && pat_mem[i] == SymAnyRun) reach[i+1] = 1'b1;
    end
  endfunction

  function automatic void restart_reach();
    reach    = '0;
    reach[0] = 1'b1;
    close_stars();
  endfunction

  function automatic void advance_reach(input logic [7:0] c);
    logic [ReachW-1:0] nxt;
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (reach[i]) begin
        if (pat_mem[i] == SymAnyRun) nxt[i] = 1'b1;
        else if (pat_mem[i] == SymAnyOne || pat_mem[i] == c) nxt[i+1] = 1'b1;
      end
    end
    reach = nxt;
    close_stars();
  endfunction

  function automatic bit match_step(input op_t op, input logic [7:0] c, output match_t res);
    res = '0;
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        restart_reach();
        return 1'b0;
      end
      OP_APPEND: begin
        if (pat_len < MaxPattern) begin
          pat_mem[pat_len] = c;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        restart_reach();
        return 1'b0;
      end
      OP_NAME: begin
        advance_reach(c);
        return 1'b0;
      end
      default: begin
        res.matched = reach[pat_len];
        res.ovf     = pat_ovf;
        restart_reach();
        return 1'b1;
      end
    endcase
  endfunction

  task automatic push_req(input op_t op, input logic [7:0] c);
    req_t r;
    r.op    = op;
    r.ch    = c;
    r.typed = 1'b0;
    r.want  = '0;
    req_q.insert(req_q.size(), r);
    n_gen++;
    if (op == OP_CLEAR) gen_pat.delete();
    else if (op == OP_APPEND && gen_pat.size() < MaxPattern) gen_pat.insert(gen_pat.size(), c);
  endtask

  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 3))
      0, 1:    return "a";
      2:       return "b";
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_pat_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return "a";
      4, 5:       return "b";
      6, 7:       return SymAnyRun;
      8:          return SymAnyOne;
      default:    return 8'($urandom);
    endcase
  endfunction

  // build a name that fits the current pattern, sometimes broken, then finish it
  task automatic feed_name();
    logic [7:0] nm [$];
    int         k;
    foreach (gen_pat[i]) begin
      if (gen_pat[i] == SymAnyRun) begin
        repeat ($urandom_range(0, 3)) nm.insert(nm.size(), pick_name_char());
      end else if (gen_pat[i] == SymAnyOne) begin
        nm.insert(nm.size(), 8'($urandom));
      end else begin
        nm.insert(nm.size(), gen_pat[i]);
      end
    end
    case ($urandom_range(0, 9))
      0: if (nm.size() > 0) nm[$urandom_range(0, nm.size() - 1)] = pick_name_char();
      1: if (nm.size() > 0) nm.delete($urandom_range(0, nm.size() - 1));
      2: nm.insert($urandom_range(0, nm.size()), pick_name_char());
      default: ;
    endcase
    k = (nm.size() > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, nm.size() - 1) : -1;
    foreach (nm[i]) begin
      if (i == k) push_req(OP_APPEND, pick_pat_char());
      push_req(OP_NAME, nm[i]);
    end
    push_req(OP_FINISH, 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
      item.mode  <= OP_CLEAR;
      item.ch    <= 8'h00;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (item.valid && item.ready) begin
        n_acc++;
        if (match_step(cur_req.op, cur_req.ch, got))
          match_q.insert(match_q.size(), cur_req.typed ? cur_req.want : got);
      end
      if (!item.valid || item.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item.valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          item.valid <= 1'b1;
          item.mode  <= cur_req.op;
          item.ch    <= cur_req.ch;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                         $urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 4);
          end
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_ph = 0;
    end else begin
      if (stall_ph == 0)
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      result.ready <= stall_pat[stall_ph[3:0]];
      stall_ph = (stall_ph + 1) % 64;
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (match_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result matched=%0b pattern_overflowed=%0b", $time,
                 result.matched, result.pattern_overflowed);
      end else begin
        want_r = match_q.pop_front();
        if (result.matched !== want_r.matched) begin
          n_errors++;
          $display("%0t: matched expected %0b actual %0b", $time, want_r.matched,
                   result.matched);
        end
        if (result.pattern_overflowed !== want_r.ovf) begin
          n_errors++;
          $display("%0t: pattern_overflowed expected %0b actual %0b", $time, want_r.ovf,
                   result.pattern_overflowed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int r;
    int long_cnt;
    item.valid   = 1'b0;
    item.mode    = OP_CLEAR;
    item.ch      = 8'h00;
    result.ready = 1'b0;
    rst          = 1'b1;
    n_gen        = 0;
    n_acc        = 0;
    n_errors     = 0;
    idle_cycles  = 0;
    long_cnt     = 0;
    pat_len      = 0;
    pat_ovf      = 1'b0;
    restart_reach();

    foreach (dir_tab[i]) begin
      push_req(dir_tab[i].op, dir_tab[i].ch);
      req_q[$].typed = dir_tab[i].typed;
      req_q[$].want  = dir_tab[i].want;
    end

    while (n_gen < NumItems + DirRows) begin
      r = $urandom_range(0, 99);
      if (r < 3 && long_cnt < 3) begin
        long_cnt++;
        push_req(OP_CLEAR, 8'($urandom));
        repeat (MaxPattern + $urandom_range(0, 4)) begin
          case ($urandom_range(0, 31))
            0:       push_req(OP_APPEND, SymAnyRun);
            1, 2:    push_req(OP_APPEND, SymAnyOne);
            3:       push_req(OP_APPEND, "b");
            default: push_req(OP_APPEND, "a");
          endcase
        end
        repeat (2) feed_name();
      end else if (r < 85) begin
        if ($urandom_range(0, 1) == 0) push_req(OP_CLEAR, 8'($urandom));
        repeat ($urandom_range(0, 6)) push_req(OP_APPEND, pick_pat_char());
        repeat ($urandom_range(1, 4)) feed_name();
      end else begin
        repeat ($urandom_range(1, 5)) push_req(op_t'($urandom_range(0, 3)), 8'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (n_acc == n_gen);
    wait (match_q.size() == 0);
    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
